### rtl/crt_pkg.sv
`timescale 1ns / 1ps

package crt_pkg;

    localparam int OPA_W  = 64;
    localparam int OPB_W  = 32;
    localparam int PROD_W = OPA_W + OPB_W;

    typedef enum logic
    {
        OP_DIV,
        OP_MUL
    } unit_op_t;

    typedef struct packed
    {
        logic             start;
        unit_op_t         op;
        logic [OPA_W-1:0] a;
        logic [OPB_W-1:0] b;
    } unit_req_t;

    typedef struct packed
    {
        logic              done;
        logic [OPA_W-1:0]  quo;
        logic [OPB_W-1:0]  rem;
        logic [PROD_W-1:0] prod;
    } unit_rsp_t;

endpackage

### rtl/crt_congruence_merger.sv
`timescale 1ns / 1ps

// Merges a stream of congruences x = remainder (mod modulus) into one running
// congruence x = combined_remainder (mod combined_modulus); moduli need not be
// coprime. Each beat returns one result beat. A single bit-serial unit does all
// the arithmetic. A full merge costs ten divides and three multiplies, plus one
// divide per step of the gcd and a divide and a multiply per step of the
// inverse search; with 32-bit moduli each loop runs at most about 46 steps.
// A sticky flag or a zero modulus skips the arithmetic. The block takes no new
// beat until the current result has been loaded into the output register.
module crt_congruence_merger import crt_pkg::*;
#(
    parameter int MOD_WIDTH = 32,
    parameter int ACC_WIDTH = 63
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        start_system,
    input  logic [31:0] remainder,
    input  logic [31:0] modulus,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [62:0] combined_remainder,
    output logic [62:0] combined_modulus,
    output logic        consistent,
    output logic        overflowed
);

    typedef enum logic [4:0]
    {
        S_IDLE, S_CHECK, S_RMOD, S_GINIT, S_GLOOP, S_GSTEP, S_CHK1, S_CHK2,
        S_MP, S_OVF, S_RM, S_DG, S_BG, S_BGM, S_ELOOP, S_EDIV, S_EMUL,
        S_KM, S_KD, S_FM, S_EMIT
    } state_t;

    state_t                 state_reg;
    unit_req_t              req_reg;
    unit_rsp_t              rsp;

    logic [ACC_WIDTH-1:0]   acc_r_reg;
    logic [ACC_WIDTH-1:0]   acc_m_reg;
    logic [ACC_WIDTH-1:0]   new_m_reg;
    logic                   nosol_reg;
    logic                   ovf_reg;
    logic [OPB_W-1:0]       r_reg;
    logic [OPB_W-1:0]       m_reg;
    logic [OPB_W-1:0]       ga_reg;
    logic [OPB_W-1:0]       gb_reg;
    logic [OPB_W-1:0]       t_reg;
    logic [OPB_W-1:0]       mp_reg;
    logic [OPB_W-1:0]       dg_reg;
    logic [OPB_W-1:0]       e0_reg;
    logic [OPB_W-1:0]       e1_reg;
    logic signed [34:0]     s0_reg;
    logic signed [34:0]     s1_reg;
    logic                   out_valid_reg;
    logic [62:0]            out_r_reg;
    logic [62:0]            out_m_reg;
    logic                   out_c_reg;
    logic                   out_o_reg;

    logic [OPB_W:0]         diff_w;
    logic signed [34:0]     prod_s;
    logic signed [34:0]     qs;
    logic signed [34:0]     inv_w;
    logic [OPB_W-1:0]       inv;
    logic [OPB_W-1:0]       s1_mag;
    logic                   accept;

    crt_unit u_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .rsp   (rsp)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        diff_w = (r_reg >= rsp.rem) ? {1'b0, r_reg} - {1'b0, rsp.rem}
                                    : {1'b0, r_reg} + {1'b0, m_reg} - {1'b0, rsp.rem};
        prod_s = $signed({1'b0, rsp.prod[33:0]});
        qs     = s1_reg[34] ? -prod_s : prod_s;
        s1_mag = s1_reg[34] ? OPB_W'(-s1_reg) : OPB_W'(s1_reg);
        inv_w  = s0_reg[34] ? s0_reg + $signed({3'b000, mp_reg}) : s0_reg;
        inv    = (inv_w[OPB_W-1:0] == mp_reg) ? '0 : inv_w[OPB_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            acc_r_reg     <= '0;
            acc_m_reg     <= ACC_WIDTH'(1);
            nosol_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_reg.start <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (start_system)
                        begin
                            acc_r_reg <= '0;
                            acc_m_reg <= ACC_WIDTH'(1);
                            nosol_reg <= 1'b0;
                            ovf_reg   <= 1'b0;
                        end
                        r_reg     <= OPB_W'(remainder[MOD_WIDTH-1:0]);
                        m_reg     <= OPB_W'(modulus[MOD_WIDTH-1:0]);
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (nosol_reg || ovf_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else if (m_reg == '0)
                    begin
                        nosol_reg <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        req_reg   <= '{1'b1, OP_DIV, OPA_W'(r_reg), m_reg};
                        state_reg <= S_RMOD;
                    end
                end
                S_RMOD:
                begin
                    if (rsp.done)
                    begin
                        r_reg     <= rsp.rem;
                        req_reg   <= '{1'b1, OP_DIV, OPA_W'(acc_m_reg), m_reg};
                        state_reg <= S_GINIT;
                    end
                end
                S_GINIT:
                begin
                    if (rsp.done)
                    begin
                        ga_reg    <= m_reg;
                        gb_reg    <= rsp.rem;
                        state_reg <= S_GLOOP;
                    end
                end
                S_GLOOP:
                begin
                    // ga holds the gcd once gb reaches zero
                    if (gb_reg == '0)
                    begin
                        req_reg   <= '{1'b1, OP_DIV, OPA_W'(r_reg), ga_reg};
                        state_reg <= S_CHK1;
                    end
                    else
                    begin
                        req_reg   <= '{1'b1, OP_DIV, OPA_W'(ga_reg), gb_reg};
                        state_reg <= S_GSTEP;
                    end
                end
                S_GSTEP:
                begin
                    if (rsp.done)
                    begin
                        ga_reg    <= gb_reg;
                        gb_reg    <= rsp.rem;
                        state_reg <= S_GLOOP;
                    end
                end
                S_CHK1:
                begin
                    if (rsp.done)
                    begin
                        t_reg     <= rsp.rem;
                        req_reg   <= '{1'b1, OP_DIV, OPA_W'(acc_r_reg), ga_reg};
                        state_reg <= S_CHK2;
                    end
                end
                S_CHK2:
                begin
                    if (rsp.done)
                    begin
                        if (rsp.rem != t_reg)
                        begin
                            nosol_reg <= 1'b1;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            req_reg   <= '{1'b1, OP_DIV, OPA_W'(m_reg), ga_reg};
                            state_reg <= S_MP;
                        end
                    end
                end
                S_MP:
                begin
                    if (rsp.done)
                    begin
                        mp_reg    <= rsp.quo[OPB_W-1:0];
                        req_reg   <= '{1'b1, OP_MUL, OPA_W'(acc_m_reg), rsp.quo[OPB_W-1:0]};
                        state_reg <= S_OVF;
                    end
                end
                S_OVF:
                begin
                    if (rsp.done)
                    begin
                        if ((rsp.prod >> ACC_WIDTH) != '0)
                        begin
                            ovf_reg   <= 1'b1;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            new_m_reg <= rsp.prod[ACC_WIDTH-1:0];
                            req_reg   <= '{1'b1, OP_DIV, OPA_W'(acc_r_reg), m_reg};
                            state_reg <= S_RM;
                        end
                    end
                end
                S_RM:
                begin
                    if (rsp.done)
                    begin
                        if (mp_reg == OPB_W'(1))
                        begin
                            // multiplier is zero: remainder holds
                            acc_m_reg <= new_m_reg;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            req_reg   <= '{1'b1, OP_DIV, OPA_W'(diff_w[OPB_W-1:0]), ga_reg};
                            state_reg <= S_DG;
                        end
                    end
                end
                S_DG:
                begin
                    if (rsp.done)
                    begin
                        dg_reg    <= rsp.quo[OPB_W-1:0];
                        req_reg   <= '{1'b1, OP_DIV, OPA_W'(acc_m_reg), ga_reg};
                        state_reg <= S_BG;
                    end
                end
                S_BG:
                begin
                    if (rsp.done)
                    begin
                        req_reg   <= '{1'b1, OP_DIV, rsp.quo, mp_reg};
                        state_reg <= S_BGM;
                    end
                end
                S_BGM:
                begin
                    if (rsp.done)
                    begin
                        e0_reg    <= mp_reg;
                        e1_reg    <= rsp.rem;
                        s0_reg    <= '0;
                        s1_reg    <= 35'sd1;
                        state_reg <= S_ELOOP;
                    end
                end
                S_ELOOP:
                begin
                    if (e1_reg == '0)
                    begin
                        req_reg   <= '{1'b1, OP_MUL, OPA_W'(dg_reg), inv};
                        state_reg <= S_KM;
                    end
                    else
                    begin
                        req_reg   <= '{1'b1, OP_DIV, OPA_W'(e0_reg), e1_reg};
                        state_reg <= S_EDIV;
                    end
                end
                S_EDIV:
                begin
                    if (rsp.done)
                    begin
                        e0_reg    <= e1_reg;
                        e1_reg    <= rsp.rem;
                        req_reg   <= '{1'b1, OP_MUL, rsp.quo, s1_mag};
                        state_reg <= S_EMUL;
                    end
                end
                S_EMUL:
                begin
                    if (rsp.done)
                    begin
                        s0_reg    <= s1_reg;
                        s1_reg    <= s0_reg - qs;
                        state_reg <= S_ELOOP;
                    end
                end
                S_KM:
                begin
                    if (rsp.done)
                    begin
                        req_reg   <= '{1'b1, OP_DIV, rsp.prod[OPA_W-1:0], mp_reg};
                        state_reg <= S_KD;
                    end
                end
                S_KD:
                begin
                    if (rsp.done)
                    begin
                        req_reg   <= '{1'b1, OP_MUL, OPA_W'(acc_m_reg), rsp.rem};
                        state_reg <= S_FM;
                    end
                end
                S_FM:
                begin
                    if (rsp.done)
                    begin
                        acc_r_reg <= acc_r_reg + rsp.prod[ACC_WIDTH-1:0];
                        acc_m_reg <= new_m_reg;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_r_reg     <= 63'(acc_r_reg);
                        out_m_reg     <= 63'(acc_m_reg);
                        out_c_reg     <= !nosol_reg;
                        out_o_reg     <= ovf_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid          = out_valid_reg;
    assign combined_remainder = out_r_reg;
    assign combined_modulus   = out_m_reg;
    assign consistent         = out_c_reg;
    assign overflowed         = out_o_reg;

endmodule

### rtl/crt_unit.sv
`timescale 1ns / 1ps

// Shared bit-serial unit: restoring divide (64 / 32, one quotient bit a cycle)
// or shift-add multiply (64 x 32, one multiplier bit a cycle).
module crt_unit import crt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  unit_req_t req,
    output unit_rsp_t rsp
);

    localparam int CNT_W = $clog2(OPA_W);

    logic              busy_reg;
    logic              done_reg;
    unit_op_t          op_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [OPA_W-1:0]  quo_reg;
    logic [OPB_W-1:0]  rem_reg;
    logic [OPB_W-1:0]  b_reg;
    logic [PROD_W-1:0] mcand_reg;
    logic [PROD_W-1:0] prod_reg;

    logic [OPB_W:0]    partial;
    logic              fits;
    logic [OPB_W-1:0]  rem_step;
    logic [CNT_W-1:0]  last_cnt;

    always_comb
    begin
        partial  = {rem_reg, quo_reg[OPA_W-1]};
        fits     = (partial >= {1'b0, b_reg});
        rem_step = fits ? OPB_W'(partial - {1'b0, b_reg}) : partial[OPB_W-1:0];
        last_cnt = (op_reg == OP_DIV) ? CNT_W'(OPA_W - 1) : CNT_W'(OPB_W - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                op_reg    <= req.op;
                cnt_reg   <= '0;
                quo_reg   <= req.a;
                rem_reg   <= '0;
                b_reg     <= req.b;
                mcand_reg <= PROD_W'(req.a);
                prod_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (op_reg == OP_DIV)
                begin
                    quo_reg <= {quo_reg[OPA_W-2:0], fits};
                    rem_reg <= rem_step;
                end
                else
                begin
                    if (b_reg[0])
                    begin
                        prod_reg <= prod_reg + mcand_reg;
                    end
                    mcand_reg <= {mcand_reg[PROD_W-2:0], 1'b0};
                    b_reg     <= {1'b0, b_reg[OPB_W-1:1]};
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == last_cnt)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
    assign rsp.rem  = rem_reg;
    assign rsp.prod = prod_reg;

endmodule

### rtl/crt_checker.sv
`timescale 1ns / 1ps

module crt_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [62:0] combined_remainder,
    input  logic [62:0] combined_modulus,
    input  logic        consistent,
    input  logic        overflowed
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(combined_remainder)
            && $stable(combined_modulus) && $stable(consistent) && $stable(overflowed))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again before the item finished");

    a_mod_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> combined_modulus != 63'd0)
        else $error("combined modulus is zero");

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> combined_remainder < combined_modulus)
        else $error("combined remainder out of range");

endmodule

bind crt_congruence_merger crt_checker u_crt_checker
(
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .combined_remainder (combined_remainder),
    .combined_modulus   (combined_modulus),
    .consistent         (consistent),
    .overflowed         (overflowed)
);

### test/tb_crt_congruence_merger.sv
`timescale 1ns / 1ps

module tb_crt_congruence_merger;

    localparam logic [63:0] ACC_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct
    {
        logic        start;
        logic [31:0] r;
        logic [31:0] m;
    } congruence_t;

    typedef struct
    {
        logic [62:0] rem;
        logic [62:0] modv;
        logic        ok;
        logic        ovf;
    } merged_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        start_system;
    logic [31:0] remainder;
    logic [31:0] modulus;
    logic        out_valid;
    logic        out_ready;
    logic [62:0] combined_remainder;
    logic [62:0] combined_modulus;
    logic        consistent;
    logic        overflowed;

    congruence_t pending_q[$];
    merged_t     merged_q[$];
    int          mismatches;
    int          beats_in;
    int          beats_out;
    int          no_sol_seen;
    int          ovf_seen;

    // predictor state
    logic [63:0] run_rem;
    logic [63:0] run_mod;
    logic        run_nosol;
    logic        run_ovf;

    crt_congruence_merger dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .start_system       (start_system),
        .remainder          (remainder),
        .modulus            (modulus),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .combined_remainder (combined_remainder),
        .combined_modulus   (combined_modulus),
        .consistent         (consistent),
        .overflowed         (overflowed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [63:0] mod_inverse(logic [63:0] a, logic [63:0] n);
        longint r0, r1, s0, s1, q, t;
        r0 = longint'(n);
        r1 = longint'(a);
        s0 = 0;
        s1 = 1;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            t  = r0 - q * r1;
            r0 = r1;
            r1 = t;
            t  = s0 - q * s1;
            s0 = s1;
            s1 = t;
        end
        if (s0 < 0)
            s0 = s0 + longint'(n);
        return 64'(s0) % n;
    endfunction

    task automatic merge_congruence(input congruence_t c, output merged_t res);
        logic [63:0] r, m, bm, br, g, mp, rm, diff, k;
        logic        skip;
        r    = {32'd0, c.r};
        m    = {32'd0, c.m};
        skip = 1'b0;
        if (c.start)
        begin
            run_rem   = 64'd0;
            run_mod   = 64'd1;
            run_nosol = 1'b0;
            run_ovf   = 1'b0;
        end
        if (run_nosol || run_ovf)
            skip = 1'b1;
        else if (m == 0)
        begin
            run_nosol = 1'b1;
            skip      = 1'b1;
        end
        if (!skip)
        begin
            bm = (run_mod == 0) ? 64'd1 : run_mod;
            br = run_rem;
            r  = r % m;
            g  = gcd64(bm, m);
            if ((r % g) != (br % g))
                run_nosol = 1'b1;
            else
            begin
                mp = m / g;
                if (bm > ACC_LIMIT / mp)
                    run_ovf = 1'b1;
                else
                begin
                    rm   = br % m;
                    diff = (r >= rm) ? (r - rm) : (r + m - rm);
                    if (mp == 1)
                        k = 64'd0;
                    else
                        k = ((diff / g) * mod_inverse((bm / g) % mp, mp)) % mp;
                    run_rem = (br + bm * k) & ACC_LIMIT;
                    run_mod = (bm * mp) & ACC_LIMIT;
                end
            end
        end
        res.rem  = run_rem[62:0];
        res.modv = run_mod[62:0];
        res.ok   = ~run_nosol;
        res.ovf  = run_ovf;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("MISMATCH beat %0d %s: got %h want %h", beats_out, what, got, want);
    endtask

    // driver: bursts of random length separated by random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        congruence_t cur;
        merged_t     res;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            start_system <= 1'b0;
            remainder    <= 32'd0;
            modulus      <= 32'd0;
            burst_left   <= 1;
            gap_left     <= 0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (in_valid)
            begin
                cur.start = start_system;
                cur.r     = remainder;
                cur.m     = modulus;
                merge_congruence(cur, res);
                merged_q.push_back(res);
                beats_in++;
                if (!res.ok)
                    no_sol_seen++;
                if (res.ovf)
                    ovf_seen++;
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                cur = pending_q.pop_front();
                start_system <= cur.start;
                remainder    <= cur.r;
                modulus      <= cur.m;
                in_valid     <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stall pattern: phases of no stall, random stall, and long holds
    int stall_phase;
    int phase_left;
    int hold_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            stall_phase <= 0;
            phase_left  <= 200;
            hold_left   <= 0;
        end
        else
        begin
            if (phase_left == 0)
            begin
                stall_phase <= $urandom_range(0, 2);
                phase_left  <= $urandom_range(100, 3000);
            end
            else
                phase_left <= phase_left - 1;
            case (stall_phase)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 9) < 6);
                default:
                begin
                    if (hold_left > 0)
                    begin
                        hold_left <= hold_left - 1;
                        out_ready <= 1'b0;
                    end
                    else
                    begin
                        out_ready <= 1'b1;
                        hold_left <= $urandom_range(0, 300);
                    end
                end
            endcase
        end
    end

    // monitor
    always @(posedge clk)
    begin
        merged_t want;
        if (rst_n && out_valid && out_ready)
        begin
            beats_out++;
            if (merged_q.size() == 0)
            begin
                mismatches++;
                $display("MISMATCH result beat %0d with nothing outstanding", beats_out);
            end
            else
            begin
                want = merged_q.pop_front();
                if (combined_remainder !== want.rem)
                    report_mismatch("combined_remainder", 64'(combined_remainder),
                                    64'(want.rem));
                if (combined_modulus !== want.modv)
                    report_mismatch("combined_modulus", 64'(combined_modulus),
                                    64'(want.modv));
                if (consistent !== want.ok)
                    report_mismatch("consistent", 64'(consistent), 64'(want.ok));
                if (overflowed !== want.ovf)
                    report_mismatch("overflowed", 64'(overflowed), 64'(want.ovf));
            end
        end
    end

    task automatic add_item(input logic s, input logic [31:0] r, input logic [31:0] m);
        congruence_t c;
        c.start = s;
        c.r     = r;
        c.m     = m;
        pending_q.push_back(c);
    endtask

    function automatic logic [31:0] pick_modulus();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12)
            return $urandom_range(1, 4095);
        else if (sel < 17)
            return $urandom_range(1, 1 << 20);
        else if (sel < 19)
            return $urandom | 32'h8000_0000;
        else
            return $urandom;
    endfunction

    initial
    begin
        logic [63:0] secret;
        logic [31:0] m;
        int          len;
        mismatches  = 0;
        beats_in    = 0;
        beats_out   = 0;
        no_sol_seen = 0;
        ovf_seen    = 0;
        run_rem     = 64'd0;
        run_mod     = 64'd1;
        run_nosol   = 1'b0;
        run_ovf     = 1'b0;

        // first beat without start merges with x = 0 mod 1
        add_item(1'b0, 32'd5, 32'd7);
        add_item(1'b1, 32'd0, 32'd1);
        add_item(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_item(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        // remainder not below modulus
        add_item(1'b1, 32'd100, 32'd9);
        add_item(1'b0, 32'd13, 32'd6);
        // zero modulus, then sticky no-solution
        add_item(1'b1, 32'd3, 32'd5);
        add_item(1'b0, 32'd3, 32'd0);
        add_item(1'b0, 32'd1, 32'd2);
        // no solution on non-coprime moduli, then sticky
        add_item(1'b1, 32'd1, 32'd4);
        add_item(1'b0, 32'd2, 32'd6);
        add_item(1'b0, 32'd1, 32'd3);
        // non-coprime with a solution, then one without
        add_item(1'b1, 32'd1, 32'd4);
        add_item(1'b0, 32'd3, 32'd6);
        add_item(1'b0, 32'd7, 32'd12);
        // lcm too wide, then sticky overflow
        add_item(1'b1, 32'd1, 32'hFFFF_FFFB);
        add_item(1'b0, 32'd2, 32'hFFFF_FFEF);
        add_item(1'b0, 32'd0, 32'd3);
        // lcm just fits
        add_item(1'b1, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        add_item(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        add_item(1'b1, 32'd0, 32'hFFFF_FFFF);

        // random systems built around a hidden solution, with noise mixed in
        while (pending_q.size() < 1950)
        begin
            secret = {$urandom, $urandom};
            len    = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
            begin
                m = pick_modulus();
                if ($urandom_range(0, 99) < 3)
                    m = 32'd0;
                if ($urandom_range(0, 99) < 12)
                    add_item(i == 0, $urandom, m);
                else if (m != 0 && $urandom_range(0, 9) == 0)
                    add_item(i == 0, 32'(secret % m) + m * $urandom_range(0, 3), m);
                else
                    add_item(i == 0, (m == 0) ? $urandom : 32'(secret % m), m);
            end
            if ($urandom_range(0, 9) == 0)
                add_item(1'($urandom_range(0, 1)), $urandom, $urandom);
        end

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !in_valid);
        wait (merged_q.size() == 0);
        repeat (200) @(posedge clk);
        $display("Merged %0d congruences, checked %0d results", beats_in, beats_out);
        $display("%0d results without solution, %0d with overflow", no_sol_seen, ovf_seen);
        if (mismatches == 0 && merged_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #800ms;
        $display("Timeout with %0d results outstanding", merged_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
